### src/shc_pkg.sv
`default_nettype none
package shc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int STRIP_W    = 7;
  localparam int TIME_W     = 10;
  localparam int HIT_W      = 24;
  localparam int OUT_NUM_W  = 6;

  localparam logic [CFG_IDX_W-1:0] REG_STRIP_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW  = 2'd1;

  localparam logic [STRIP_W-1:0] STRIP_WINDOW_RST = 7'd4;
  localparam logic [TIME_W-1:0]  TIME_WINDOW_RST  = 10'd5;

  typedef struct packed {
    logic [TIME_W-1:0]  hit_time;
    logic [STRIP_W-1:0] strip;
    logic [1:0]         layer;
    logic               coordinate;
    logic [3:0]         chamber;
  } hit_t;

  typedef enum logic [6:0] {
    ST_LOAD    = 7'b0000001,
    ST_FETCH_Q = 7'b0000010,
    ST_FETCH_H = 7'b0000100,
    ST_CAND    = 7'b0001000,
    ST_MRD     = 7'b0010000,
    ST_MCMP    = 7'b0100000,
    ST_EMIT    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic ld;
    logic init;
    logic cap_idx;
    logic cap_hit;
    logic scan_start;
    logic next_member;
    logic open_new;
    logic rotate;
    logic emit;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic eoe;
    logic open;
    logic match;
    logic last_member;
    logic miss_full;
    logic last_pending;
    logic out_fire;
  } sts_t;

endpackage
`default_nettype wire

### src/strip_hit_clusterer_core.sv
// Channel | Dir | tdata                                      | tuser           | tlast
// in_     | in  | chamber,coordinate,layer,strip,time (24)   | -               | end of event
// out_    | out | cluster,hit number,chamber..time (40)      | first,dropped   | last of event
// cfg_    | in  | write: index 0 strip window, 1 time window | -               | -
// Hits load one per cycle while the core is in its load state. Clustering then fetches
// the queue entry and its hit, scans the cluster members (read, then compare) and emits
// each hit; the member scan through the single read port of the member memory dominates.
// Reset is synchronous and active low; stalled output holds the hit and the FSM.
`default_nettype none
module strip_hit_clusterer_core #(
  parameter int MAX_HITS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [shc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [shc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [23:0]                    in_tdata,   // chamber, coordinate, layer, strip, time
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [39:0]                         out_tdata,  // cluster, hit number, chamber,
                                                          // coordinate, layer, strip, time
  output logic [1:0]                          out_tuser,  // first_in_cluster, hits_dropped
  output logic                                out_tlast
);
  import shc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign in_tready  = cmd.ld;
  assign out_tvalid = cmd.emit;

  shc_ctrl u_ctrl (.clk, .rst_n, .sts, .cmd);

  shc_datapath #(.MAX_HITS(MAX_HITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_wr_en, .cfg_index, .cfg_wr_data,
    .in_tvalid, .in_tdata, .in_tlast, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );
endmodule
`default_nettype wire

### src/shc_ram.sv
`default_nettype none
module shc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/shc_ctrl.sv
`default_nettype none
module shc_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire shc_pkg::sts_t sts,
  output shc_pkg::cmd_t      cmd
);
  import shc_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        cmd.ld = 1'b1;
        if (sts.in_fire && sts.eoe) begin
          cmd.init  = 1'b1;
          state_nxt = ST_FETCH_Q;
        end
      end
      ST_FETCH_Q: state_nxt = ST_FETCH_H;
      ST_FETCH_H: begin
        cmd.cap_idx = 1'b1;
        state_nxt   = ST_CAND;
      end
      ST_CAND: begin
        cmd.cap_hit = 1'b1;
        if (sts.open) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_MRD;
        end
      end
      ST_MRD: state_nxt = ST_MCMP;
      ST_MCMP: begin
        priority if (sts.match) begin
          state_nxt = ST_EMIT;
        end else if (!sts.last_member) begin
          cmd.next_member = 1'b1;
          state_nxt       = ST_MRD;
        end else if (sts.miss_full) begin
          cmd.open_new = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.rotate = 1'b1;
          state_nxt  = ST_FETCH_Q;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.out_fire) begin
          cmd.emit_done = 1'b1;
          state_nxt     = sts.last_pending ? ST_LOAD : ST_FETCH_Q;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

### src/shc_datapath.sv
`default_nettype none
module shc_datapath #(
  parameter int MAX_HITS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire shc_pkg::cmd_t                  cmd,
  output shc_pkg::sts_t                       sts,
  input  wire logic                           cfg_wr_en,
  input  wire logic [shc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [shc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  wire logic                           in_tvalid,
  input  wire logic [23:0]                    in_tdata,
  input  wire logic                           in_tlast,
  input  wire logic                           out_tready,
  output logic [39:0]                         out_tdata,
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast
);
  import shc_pkg::*;

  localparam int IW = $clog2(MAX_HITS);
  localparam int CW = $clog2(MAX_HITS + 1);

  logic [STRIP_W-1:0] strip_win_r;
  logic [TIME_W-1:0]  time_win_r;
  logic [CW-1:0]      hit_count_r, pending_r, miss_r, member_count_r;
  logic [IW-1:0]      head_r, cand_idx_r, mi_r, cluster_r;
  logic               overflow_r, open_r;
  hit_t               cand_r, m_hit;
  logic [HIT_W-1:0]   h_rdata, m_rdata;
  logic [IW-1:0]      q_rdata, q_waddr, q_wdata, tail, head_inc, m_waddr;
  logic               q_we, h_we, room;
  logic [CW:0]        tail_sum;
  logic [STRIP_W-1:0] d_strip;
  logic [TIME_W-1:0]  d_time;

  assign m_hit   = hit_t'(m_rdata);
  assign room    = hit_count_r < CW'(MAX_HITS);
  assign sts.in_fire  = cmd.ld && in_tvalid;
  assign sts.eoe      = in_tlast;
  assign sts.open     = open_r;
  assign sts.out_fire = cmd.emit && out_tready;
  assign sts.last_member  = (CW'(mi_r) + CW'(1)) == member_count_r;
  assign sts.miss_full    = (miss_r + CW'(1)) == pending_r;
  assign sts.last_pending = pending_r == CW'(1);

  assign d_strip = (cand_r.strip >= m_hit.strip) ? cand_r.strip - m_hit.strip
                                                 : m_hit.strip - cand_r.strip;
  assign d_time  = (cand_r.hit_time >= m_hit.hit_time) ? cand_r.hit_time - m_hit.hit_time
                                                       : m_hit.hit_time - cand_r.hit_time;
  assign sts.match = cand_r.chamber == m_hit.chamber && cand_r.coordinate == m_hit.coordinate &&
                     cand_r.layer == m_hit.layer && d_strip <= strip_win_r &&
                     d_time <= time_win_r;

  assign head_inc = (head_r == IW'(MAX_HITS - 1)) ? '0 : head_r + IW'(1);
  assign tail_sum = (CW+1)'(head_r) + (CW+1)'(pending_r);
  assign tail     = (tail_sum >= (CW+1)'(MAX_HITS)) ? IW'(tail_sum - (CW+1)'(MAX_HITS))
                                                    : IW'(tail_sum);

  assign h_we    = sts.in_fire && room;
  assign q_we    = h_we || cmd.rotate;
  assign q_waddr = cmd.rotate ? tail : hit_count_r[IW-1:0];
  assign q_wdata = cmd.rotate ? cand_idx_r : hit_count_r[IW-1:0];
  assign m_waddr = open_r ? '0 : member_count_r[IW-1:0];

  shc_ram #(.WIDTH(HIT_W), .DEPTH(MAX_HITS)) u_hit_ram (
    .clk, .we(h_we), .waddr(hit_count_r[IW-1:0]), .wdata(in_tdata),
    .raddr(q_rdata), .rdata(h_rdata)
  );

  shc_ram #(.WIDTH(IW), .DEPTH(MAX_HITS)) u_queue_ram (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head_r), .rdata(q_rdata)
  );

  shc_ram #(.WIDTH(HIT_W), .DEPTH(MAX_HITS)) u_member_ram (
    .clk, .we(cmd.emit_done), .waddr(m_waddr), .wdata(HIT_W'(cand_r)),
    .raddr(mi_r), .rdata(m_rdata)
  );

  assign out_tdata = {4'd0, cand_r.hit_time, cand_r.strip, cand_r.layer, cand_r.coordinate,
                      cand_r.chamber, OUT_NUM_W'(cand_idx_r), OUT_NUM_W'(cluster_r)};
  assign out_tuser = {overflow_r, open_r};
  assign out_tlast = sts.last_pending;

  always_ff @(posedge clk) begin
    if (cmd.cap_idx) begin
      cand_idx_r <= q_rdata;
    end
    if (cmd.cap_hit) begin
      cand_r <= hit_t'(h_rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_win_r    <= STRIP_WINDOW_RST;
      time_win_r     <= TIME_WINDOW_RST;
      hit_count_r    <= '0;
      pending_r      <= '0;
      miss_r         <= '0;
      member_count_r <= '0;
      head_r         <= '0;
      mi_r           <= '0;
      cluster_r      <= '0;
      overflow_r     <= 1'b0;
      open_r         <= 1'b0;
    end else begin
      if (cfg_wr_en && cfg_index == REG_STRIP_WINDOW) begin
        strip_win_r <= cfg_wr_data[STRIP_W-1:0];
      end
      if (cfg_wr_en && cfg_index == REG_TIME_WINDOW) begin
        time_win_r <= cfg_wr_data[TIME_W-1:0];
      end
      if (sts.in_fire) begin
        if (room) begin
          hit_count_r <= hit_count_r + CW'(1);
        end else begin
          overflow_r <= 1'b1;
        end
      end
      if (cmd.init) begin
        pending_r <= room ? hit_count_r + CW'(1) : hit_count_r;
        head_r    <= '0;
        miss_r    <= '0;
        open_r    <= 1'b1;
      end
      if (cmd.scan_start) begin
        mi_r <= '0;
      end
      if (cmd.next_member) begin
        mi_r <= mi_r + IW'(1);
      end
      if (cmd.open_new) begin
        cluster_r <= cluster_r + IW'(1);
        open_r    <= 1'b1;
      end
      if (cmd.rotate) begin
        head_r <= head_inc;
        miss_r <= miss_r + CW'(1);
      end
      if (cmd.emit_done) begin
        head_r         <= head_inc;
        pending_r      <= pending_r - CW'(1);
        miss_r         <= '0;
        open_r         <= 1'b0;
        member_count_r <= open_r ? CW'(1) : member_count_r + CW'(1);
        if (sts.last_pending) begin
          hit_count_r    <= '0;
          overflow_r     <= 1'b0;
          cluster_r      <= '0;
          member_count_r <= '0;
        end
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hit_count_r <= CW'(MAX_HITS)) else $error("hit count beyond store depth");
  a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> pending_r != '0) else $error("emit with empty queue");
  a_rotate_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rotate |-> !sts.last_pending && miss_r < pending_r) else $error("bad rotate");
  a_event_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_done && sts.last_pending |=> hit_count_r == '0 && !overflow_r)
    else $error("event state not cleared");
`endif
endmodule
`default_nettype wire
